// ===== sv/pgf_pkg.sv =====
package pgf_pkg;

    // Partial products of the wide multipliers are built from slices of this width.
    localparam int CHUNK_BITS = 32;

    // Configuration register file.
    localparam int CFG_IDX_BITS = 2;
    localparam int CUTOFF_RESET_UNITS = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRAVITY = 2'd0,
        CFG_CUTOFF  = 2'd1
    } cfg_reg_t;

endpackage

// ===== sv/pgf_mul.sv =====
module pgf_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    import pgf_pkg::*;

    localparam int NA = (AW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NB = (BW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NP = NA * NB;
    localparam int FW = (NA + NB) * CHUNK_BITS;

    logic [NA*CHUNK_BITS-1:0] a_ext;
    logic [NB*CHUNK_BITS-1:0] b_ext;
    logic [2*CHUNK_BITS-1:0]  pp_reg [NP];
    logic [FW-1:0]            sum_next;
    logic [AW+BW-1:0]         p_reg;

    assign a_ext = (NA*CHUNK_BITS)'(a);
    assign b_ext = (NB*CHUNK_BITS)'(b);

    // First stage: every slice pair multiplied on its own.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i*NB+j] <= (2*CHUNK_BITS)'(a_ext[i*CHUNK_BITS +: CHUNK_BITS])
                                * (2*CHUNK_BITS)'(b_ext[j*CHUNK_BITS +: CHUNK_BITS]);
            end
        end
    end

    // Second stage: the shifted partial products are added up.
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NP; k++)
        begin
            sum_next = sum_next + (FW'(pp_reg[k]) << (CHUNK_BITS * (k / NB + k % NB)));
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= sum_next[AW+BW-1:0];
    end

    assign p = p_reg;

endmodule

// ===== sv/pgf_div.sv =====
module pgf_div #(
    parameter int NW = 129,
    parameter int DW = 99,
    parameter int QW = 33
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quot,
    output logic          ovf
);
    import pgf_pkg::*;

    localparam int EW = (NW > DW + QW) ? NW : DW + QW;

    logic [EW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [QW-1:0] quot_reg [0:QW];
    logic          ovf_reg  [0:QW];

    // Entry stage: flag quotients that do not fit in QW bits.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= EW'(num);
        den_reg[0]  <= den;
        quot_reg[0] <= '0;
        ovf_reg[0]  <= EW'(num) >= (EW'(den) << QW);
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int BIT = QW - k;
        logic [EW-1:0] shifted;

        assign shifted = EW'(den_reg[k-1]) << BIT;

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            if (rem_reg[k-1] >= shifted)
            begin
                rem_reg[k]  <= rem_reg[k-1] - shifted;
                quot_reg[k] <= quot_reg[k-1] | (QW'(1) << BIT);
            end
            else
            begin
                rem_reg[k]  <= rem_reg[k-1];
                quot_reg[k] <= quot_reg[k-1];
            end
        end
    end

    assign quot = quot_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

// ===== sv/pairwise_gravity_force_top.sv =====
// Each accepted start yields its own done strobe at the end of the pipeline.
// Throughput: one pair per cycle; busy stays low and start may be held high every cycle.
// The depth comes from the bit-per-stage square root and the bit-per-stage dividers.
// Reset clears the valid pipeline and loads G = 1.0 and cutoff = 5.0.
// The receiver cannot stall; each result is shown for exactly one cycle.
module pairwise_gravity_force_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [WORD_BITS-1:0]         first_pos_x,
    input  logic signed [WORD_BITS-1:0]         first_pos_y,
    input  logic signed [WORD_BITS-1:0]         second_pos_x,
    input  logic signed [WORD_BITS-1:0]         second_pos_y,
    input  logic [WORD_BITS-1:0]                first_mass,
    input  logic [WORD_BITS-1:0]                second_mass,
    output logic                                done,
    output logic signed [WORD_BITS-1:0]         force_first_x,
    output logic signed [WORD_BITS-1:0]         force_first_y,
    output logic signed [WORD_BITS-1:0]         force_second_x,
    output logic signed [WORD_BITS-1:0]         force_second_y,
    output logic                                skipped,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pgf_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [WORD_BITS-1:0]                cfg_wdata
);
    import pgf_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int AW  = W + 1;          // magnitude of a coordinate difference
    localparam int SW  = 2 * W + 2;      // squared distance
    localparam int RW  = W + 1;          // integer square root
    localparam int DW  = SW + RW;        // s * d
    localparam int PW  = 3 * W;          // G * m1 * m2
    localparam int NW  = PW + AW;        // numerator per axis
    localparam int QW  = W + 1;          // quotient bits before clipping
    localparam int ND  = RW - 1;         // numerator wait for the denominator
    localparam int TQ  = 2 * W + 9;      // stage where the quotients appear
    localparam int LAT = TQ + 1;

    localparam logic [W-1:0]  GRAV_RESET = W'(1) << FRAC_BITS;
    localparam logic [W-1:0]  CUT_RESET  = W'(CUTOFF_RESET_UNITS) << FRAC_BITS;
    localparam logic [QW-1:0] LIM_Q      = QW'(1) << (W - 1);
    localparam logic [W-1:0]  LIM_W      = W'(1) << (W - 1);
    localparam logic [W-1:0]  MAX_POS    = LIM_W - W'(1);

    // Clip one axis quotient and spread it over both bodies: {clip, second, first}.
    function automatic logic [2*W:0] axis_pick(input logic [QW-1:0] q, input logic ovf,
                                               input logic neg);
        logic         clip;
        logic         big;
        logic [W-1:0] posm;
        logic [W-1:0] negm;
        logic [W-1:0] negv;
        clip = ovf || (q >= LIM_Q);
        big  = ovf || (q > LIM_Q);
        posm = clip ? MAX_POS : q[W-1:0];
        negm = big ? LIM_W : q[W-1:0];
        negv = ~negm + W'(1);
        return neg ? {clip, negv, posm} : {clip, posm, negv};
    endfunction

    logic [W-1:0] grav_reg;
    logic [W-1:0] cut_reg;

    logic            accept;
    logic signed [W:0] dx_next;
    logic signed [W:0] dy_next;

    logic [AW-1:0] ax_reg;
    logic [AW-1:0] ay_reg;
    logic [W-1:0]  m1_reg;
    logic [W-1:0]  m2_reg;
    logic [W-1:0]  g_item_reg;
    logic [W-1:0]  cut_item_reg;
    logic [W-1:0]  m2_dly_reg [0:1];
    logic [AW-1:0] ax_dly_reg [0:3];
    logic [AW-1:0] ay_dly_reg [0:3];

    logic [SW-1:0]  ax2;
    logic [SW-1:0]  ay2;
    logic [2*W-1:0] cut2;
    logic [2*W-1:0] gm1;
    logic [PW-1:0]  prod;
    logic [NW-1:0]  numx;
    logic [NW-1:0]  numy;
    logic [DW-1:0]  den;

    logic [SW-1:0] s_next;
    logic          skip_next;

    logic [SW-1:0] sq_s_reg    [0:RW];
    logic [SW-1:0] sq_rem_reg  [0:RW];
    logic [RW-1:0] sq_root_reg [0:RW];

    logic [NW-1:0] numx_dly_reg [1:ND];
    logic [NW-1:0] numy_dly_reg [1:ND];

    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          ovx;
    logic          ovy;

    logic       vld_reg  [1:TQ];
    logic [1:0] sgn_reg  [1:TQ];
    logic       skip_reg [4:TQ];

    logic [2*W:0] pick_x;
    logic [2*W:0] pick_y;

    logic         done_reg;
    logic [W-1:0] ffx_reg;
    logic [W-1:0] ffy_reg;
    logic [W-1:0] fsx_reg;
    logic [W-1:0] fsy_reg;
    logic         skipped_reg;
    logic         saturated_reg;
    logic [W-1:0] ffx_next;
    logic [W-1:0] ffy_next;
    logic [W-1:0] fsx_next;
    logic [W-1:0] fsy_next;
    logic         saturated_next;

    // Handshakes: the pipeline never stalls.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= GRAV_RESET;
            cut_reg  <= CUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_GRAVITY: grav_reg <= cfg_wdata;
                CFG_CUTOFF:  cut_reg  <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Stage 1: coordinate differences as sign and magnitude.
    assign dx_next = (W+1)'(first_pos_x) - (W+1)'(second_pos_x);
    assign dy_next = (W+1)'(first_pos_y) - (W+1)'(second_pos_y);

    always_ff @(posedge clk)
    begin
        ax_reg       <= dx_next[W] ? AW'(~dx_next + 1'b1) : AW'(dx_next);
        ay_reg       <= dy_next[W] ? AW'(~dy_next + 1'b1) : AW'(dy_next);
        m1_reg       <= first_mass;
        m2_reg       <= second_mass;
        g_item_reg   <= grav_reg;
        cut_item_reg <= cut_reg;
        m2_dly_reg[0] <= m2_reg;
        m2_dly_reg[1] <= m2_dly_reg[0];
        ax_dly_reg[0] <= ax_reg;
        ay_dly_reg[0] <= ay_reg;
        for (int i = 1; i < 4; i++)
        begin
            ax_dly_reg[i] <= ax_dly_reg[i-1];
            ay_dly_reg[i] <= ay_dly_reg[i-1];
        end
    end

    // Squares, cutoff square and the mass product.
    pgf_mul #(.AW(AW), .BW(AW)) u_mul_ax (.clk(clk), .a(ax_reg), .b(ax_reg), .p(ax2));
    pgf_mul #(.AW(AW), .BW(AW)) u_mul_ay (.clk(clk), .a(ay_reg), .b(ay_reg), .p(ay2));
    pgf_mul #(.AW(W), .BW(W)) u_mul_cut (.clk(clk), .a(cut_item_reg), .b(cut_item_reg),
                                         .p(cut2));
    pgf_mul #(.AW(W), .BW(W)) u_mul_gm (.clk(clk), .a(g_item_reg), .b(m1_reg), .p(gm1));
    pgf_mul #(.AW(2*W), .BW(W)) u_mul_p (.clk(clk), .a(gm1), .b(m2_dly_reg[1]), .p(prod));
    pgf_mul #(.AW(PW), .BW(AW)) u_mul_nx (.clk(clk), .a(prod), .b(ax_dly_reg[3]), .p(numx));
    pgf_mul #(.AW(PW), .BW(AW)) u_mul_ny (.clk(clk), .a(prod), .b(ay_dly_reg[3]), .p(numy));

    // Stage 4: squared distance and the skip decision.
    assign s_next    = ax2 + ay2;
    assign skip_next = (s_next == '0) || (s_next < SW'(cut2));

    always_ff @(posedge clk)
    begin
        sq_s_reg[0]    <= s_next;
        sq_rem_reg[0]  <= s_next;
        sq_root_reg[0] <= '0;
    end

    // Integer square root, one root bit per stage.
    for (genvar k = 1; k <= RW; k++)
    begin : g_sqrt
        localparam int BIT = RW - k;
        logic [SW-1:0] trial;

        assign trial = (SW'(sq_root_reg[k-1]) << (BIT + 1)) | (SW'(1) << (2 * BIT));

        always_ff @(posedge clk)
        begin
            sq_s_reg[k] <= sq_s_reg[k-1];
            if (sq_rem_reg[k-1] >= trial)
            begin
                sq_rem_reg[k]  <= sq_rem_reg[k-1] - trial;
                sq_root_reg[k] <= sq_root_reg[k-1] | (RW'(1) << BIT);
            end
            else
            begin
                sq_rem_reg[k]  <= sq_rem_reg[k-1];
                sq_root_reg[k] <= sq_root_reg[k-1];
            end
        end
    end

    // Denominator s * d.
    pgf_mul #(.AW(SW), .BW(RW)) u_mul_den (.clk(clk), .a(sq_s_reg[RW]), .b(sq_root_reg[RW]),
                                           .p(den));

    // Numerators wait here until the denominator is ready.
    always_ff @(posedge clk)
    begin
        numx_dly_reg[1] <= numx;
        numy_dly_reg[1] <= numy;
        for (int i = 2; i <= ND; i++)
        begin
            numx_dly_reg[i] <= numx_dly_reg[i-1];
            numy_dly_reg[i] <= numy_dly_reg[i-1];
        end
    end

    pgf_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
        .clk(clk), .num(numx_dly_reg[ND]), .den(den), .quot(qx), .ovf(ovx)
    );
    pgf_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
        .clk(clk), .num(numy_dly_reg[ND]), .den(den), .quot(qy), .ovf(ovy)
    );

    // Valid bits travel with the item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= TQ; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[1] <= accept;
            for (int i = 2; i <= TQ; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[TQ];
        end
    end

    // Direction signs and the skip flag follow the item to the end.
    always_ff @(posedge clk)
    begin
        sgn_reg[1] <= {dx_next[W], dy_next[W]};
        for (int i = 2; i <= TQ; i++)
        begin
            sgn_reg[i] <= sgn_reg[i-1];
        end
        skip_reg[4] <= skip_next;
        for (int i = 5; i <= TQ; i++)
        begin
            skip_reg[i] <= skip_reg[i-1];
        end
    end

    // Last stage: clipping, signs and the skipped case.
    always_comb
    begin
        pick_x = axis_pick(qx, ovx, sgn_reg[TQ][1]);
        pick_y = axis_pick(qy, ovy, sgn_reg[TQ][0]);
        if (skip_reg[TQ])
        begin
            ffx_next       = '0;
            ffy_next       = '0;
            fsx_next       = '0;
            fsy_next       = '0;
            saturated_next = 1'b0;
        end
        else
        begin
            fsx_next       = pick_x[2*W-1:W];
            ffx_next       = pick_x[W-1:0];
            fsy_next       = pick_y[2*W-1:W];
            ffy_next       = pick_y[W-1:0];
            saturated_next = pick_x[2*W] || pick_y[2*W];
        end
    end

    always_ff @(posedge clk)
    begin
        ffx_reg       <= ffx_next;
        ffy_reg       <= ffy_next;
        fsx_reg       <= fsx_next;
        fsy_reg       <= fsy_next;
        skipped_reg   <= skip_reg[TQ];
        saturated_reg <= saturated_next;
    end

    assign done           = done_reg;
    assign force_first_x  = ffx_reg;
    assign force_first_y  = ffy_reg;
    assign force_second_x = fsx_reg;
    assign force_second_y = fsy_reg;
    assign skipped        = skipped_reg;
    assign saturated      = saturated_reg;

`ifndef NO_ASSERTIONS
    // Every accepted pair comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted pair did not complete after the pipeline latency");

    // A skipped pair carries no force and no clipping.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && skipped |-> force_first_x == '0 && force_first_y == '0 &&
                            force_second_x == '0 && force_second_y == '0 && !saturated)
        else $error("skipped pair produced a nonzero force");

    // Without clipping the two bodies get exactly opposite forces.
    a_newton_third: assert property (@(posedge clk) disable iff (!rst_n)
        done && !saturated |-> W'(force_first_x + force_second_x) == '0 &&
                               W'(force_first_y + force_second_y) == '0)
        else $error("forces on the two bodies are not opposite");

    // Clipping only happens on pairs that were evaluated.
    a_sat_not_skip: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> !skipped)
        else $error("saturation flagged on a skipped pair");
`endif

endmodule

// ===== dv/pairwise_gravity_force_top_test.sv =====
module pairwise_gravity_force_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgf_pkg::*;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int LATENCY = 2 * WB + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic signed [WB-1:0] p1x;
        logic signed [WB-1:0] p1y;
        logic signed [WB-1:0] p2x;
        logic signed [WB-1:0] p2y;
        logic [WB-1:0]        m1;
        logic [WB-1:0]        m2;
    } body_pair_t;

    typedef struct packed {
        logic signed [WB-1:0] f1x;
        logic signed [WB-1:0] f1y;
        logic signed [WB-1:0] f2x;
        logic signed [WB-1:0] f2y;
        logic                 skip;
        logic                 sat;
    } pair_force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [WB-1:0] first_pos_x = '0;
    logic signed [WB-1:0] first_pos_y = '0;
    logic signed [WB-1:0] second_pos_x = '0;
    logic signed [WB-1:0] second_pos_y = '0;
    logic [WB-1:0] first_mass = '0;
    logic [WB-1:0] second_mass = '0;
    logic done;
    logic signed [WB-1:0] force_first_x;
    logic signed [WB-1:0] force_first_y;
    logic signed [WB-1:0] force_second_x;
    logic signed [WB-1:0] force_second_y;
    logic skipped;
    logic saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [WB-1:0] cfg_wdata = '0;

    // Model copy of the two registers.
    logic [WB-1:0] grav_g;
    logic [WB-1:0] cutoff_d;

    pair_force_t force_queue[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;

    pairwise_gravity_force_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_pos_x(first_pos_x), .first_pos_y(first_pos_y),
        .second_pos_x(second_pos_x), .second_pos_y(second_pos_y),
        .first_mass(first_mass), .second_mass(second_mass),
        .done(done), .force_first_x(force_first_x), .force_first_y(force_first_y),
        .force_second_x(force_second_x), .force_second_y(force_second_y),
        .skipped(skipped), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    // Integer square root, floor, one bit per step.
    function automatic wide_t floor_root(input wide_t s);
        wide_t root;
        wide_t c;
        root = '0;
        for (int b = 52; b >= 0; b--) begin
            c = root | (wide_t'(1) << b);
            if (c * c <= s)
                root = c;
        end
        return root;
    endfunction

    // One axis of the force: fills the second and first body components.
    function automatic logic axis_pull(input wide_t prod, input logic signed [WB+1:0] delta,
                                       input wide_t den, output logic [WB-1:0] f_second,
                                       output logic [WB-1:0] f_first);
        wide_t lim;
        wide_t mag;
        wide_t q;
        wide_t posm;
        wide_t negm;
        lim = wide_t'(1) << (WB - 1);
        mag = delta < 0 ? wide_t'(-delta) : wide_t'(delta);
        q = (prod * mag) / den;
        if (q > lim)
            q = lim + 1;
        posm = q > lim - 1 ? lim - 1 : q;
        negm = q > lim ? lim : q;
        if (delta >= 0) begin
            f_second = posm[WB-1:0];
            f_first = -negm[WB-1:0];
        end
        else begin
            f_second = -negm[WB-1:0];
            f_first = posm[WB-1:0];
        end
        return q >= lim;
    endfunction

    function automatic pair_force_t predict_forces(input body_pair_t pr);
        pair_force_t r;
        logic signed [WB+1:0] dx;
        logic signed [WB+1:0] dy;
        wide_t ax;
        wide_t ay;
        wide_t s;
        wide_t c2;
        wide_t d;
        wide_t den;
        wide_t prod;
        logic cx;
        logic cy;
        logic [WB-1:0] a;
        logic [WB-1:0] b;
        r = '0;
        dx = $signed({{2{pr.p1x[WB-1]}}, pr.p1x}) - $signed({{2{pr.p2x[WB-1]}}, pr.p2x});
        dy = $signed({{2{pr.p1y[WB-1]}}, pr.p1y}) - $signed({{2{pr.p2y[WB-1]}}, pr.p2y});
        ax = dx < 0 ? wide_t'(-dx) : wide_t'(dx);
        ay = dy < 0 ? wide_t'(-dy) : wide_t'(dy);
        s = ax * ax + ay * ay;
        c2 = wide_t'(cutoff_d) * wide_t'(cutoff_d);
        if (s == 0 || s < c2) begin
            r.skip = 1'b1;
            return r;
        end
        d = floor_root(s);
        den = s * d;
        prod = wide_t'(grav_g) * wide_t'(pr.m1) * wide_t'(pr.m2);
        cx = axis_pull(prod, dx, den, a, b);
        r.f2x = a;
        r.f1x = b;
        cy = axis_pull(prod, dy, den, a, b);
        r.f2y = a;
        r.f1y = b;
        r.sat = cx | cy;
        return r;
    endfunction

    // Compare each done beat with the oldest expectation.
    always @(posedge clk) begin
        pair_force_t exp_f;
        pair_force_t got;
        if (rst_n && done) begin
            got = '{force_first_x, force_first_y, force_second_x, force_second_y,
                    skipped, saturated};
            if (force_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
            end
            else begin
                exp_f = force_queue.pop_front();
                if (got !== exp_f) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected f1=(%h,%h) f2=(%h,%h) sk=%b sat=%b,",
                                  " got f1=(%h,%h) f2=(%h,%h) sk=%b sat=%b"},
                                 exp_f.f1x, exp_f.f1y, exp_f.f2x, exp_f.f2y,
                                 exp_f.skip, exp_f.sat,
                                 got.f1x, got.f1y, got.f2x, got.f2y, got.skip, got.sat);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one pair beat; bursts of random length separated by random gaps.
    task automatic send_pair(input body_pair_t pr);
        int gap;
        start <= 1'b1;
        first_pos_x <= pr.p1x;
        first_pos_y <= pr.p1y;
        second_pos_x <= pr.p2x;
        second_pos_y <= pr.p2y;
        first_mass <= pr.m1;
        second_mass <= pr.m2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        force_queue.push_back(predict_forces(pr));
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for every expected result, then the pipeline depth.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (force_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WB-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_GRAVITY)
            grav_g = val;
        else if (idx == CFG_CUTOFF)
            cutoff_d = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [WB-1:0] rand_mass;
        logic [WB-1:0] m;
        m = $urandom;
        return m >> $urandom_range(0, 31);
    endfunction

    // Mostly close pairs so forces are meaningful; some pairs fully random.
    function automatic body_pair_t rand_pair;
        body_pair_t pr;
        logic signed [WB-1:0] off;
        pr.p1x = $urandom;
        pr.p1y = $urandom;
        if ($urandom_range(0, 4) == 0) begin
            pr.p2x = $urandom;
            pr.p2y = $urandom;
        end
        else begin
            off = $urandom_range(0, 1 << $urandom_range(2, 24));
            pr.p2x = $urandom_range(0, 1) ? pr.p1x + off : pr.p1x - off;
            off = $urandom_range(0, 1 << $urandom_range(2, 24));
            pr.p2y = $urandom_range(0, 1) ? pr.p1y + off : pr.p1y - off;
        end
        pr.m1 = rand_mass();
        pr.m2 = rand_mass();
        return pr;
    endfunction

    task automatic random_pairs(input int n);
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
    endtask

    // Extremes of positions and masses, coincident, below and at cutoff, zero mass.
    task automatic test_directed_cases;
        localparam logic signed [WB-1:0] PMAX = 32'sh7fffffff;
        localparam logic signed [WB-1:0] PMIN = 32'sh80000000;
        localparam logic [WB-1:0] MMAX = '1;
        localparam logic [WB-1:0] ONE = 32'h0001_0000;
        send_pair('{0, 0, 0, 0, ONE, ONE});
        send_pair('{PMAX, PMAX, PMIN, PMIN, MMAX, MMAX});
        send_pair('{PMIN, PMIN, PMAX, PMAX, MMAX, MMAX});
        send_pair('{PMIN, 0, PMAX, 0, ONE, ONE});
        send_pair('{0, PMAX, 0, PMIN, ONE, ONE});
        send_pair('{0, 0, 32'sh0004_0000, 0, ONE, ONE});
        send_pair('{0, 0, 32'sh0005_0000, 0, ONE, ONE});
        send_pair('{0, 0, 0, -32'sh0005_0000, ONE, ONE});
        send_pair('{32'sh0003_0000, 32'sh0004_0000, 0, 0, ONE, ONE});
        send_pair('{0, 0, 32'sh0010_0000, 32'sh0010_0000, 0, ONE});
        send_pair('{0, 0, 32'sh0010_0000, -32'sh0010_0000, ONE, 0});
        send_pair('{0, 0, 32'sh0006_0000, 0, MMAX, MMAX});
        send_pair('{-32'sh0006_0000, 0, 0, 32'sh0006_0000, MMAX, 32'h0100_0000});
        send_pair('{5, 7, 5, 7, MMAX, MMAX});
        drain();
    endtask

    task automatic test_strong_gravity_no_cutoff;
        write_reg(CFG_GRAVITY, '1);
        write_reg(CFG_CUTOFF, '0);
        send_pair('{0, 0, 0, 0, 1, 1});
        send_pair('{0, 0, 1, 0, 1, 1});
        send_pair('{0, 0, 1, 1, '1, '1});
        send_pair('{32'sh7fffffff, 0, 32'sh80000000, 0, 1, 1});
        random_pairs(120);
        drain();
    endtask

    task automatic test_zero_gravity;
        write_reg(CFG_GRAVITY, '0);
        write_reg(CFG_CUTOFF, '1);
        send_pair('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, '1, '1});
        random_pairs(40);
        drain();
        write_reg(CFG_CUTOFF, 32'h0000_0100);
        random_pairs(60);
        drain();
    endtask

    task automatic test_random_settings;
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_GRAVITY, $urandom >> $urandom_range(0, 24));
            write_reg(CFG_CUTOFF, $urandom >> $urandom_range(8, 31));
            random_pairs(100);
            drain();
        end
    endtask

    // Writes to unused indexes must leave both registers alone.
    task automatic test_spare_register_writes;
        write_reg(CFG_GRAVITY, 32'h0002_0000);
        write_reg(CFG_CUTOFF, 32'h0001_0000);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        random_pairs(80);
        drain();
    endtask

    initial begin
        grav_g = WB'(1) << FB;
        cutoff_d = WB'(CUTOFF_RESET_UNITS) << FB;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        random_pairs(120);
        drain();
        test_strong_gravity_no_cutoff();
        test_zero_gravity();
        test_random_settings();
        test_spare_register_writes();
        if (mismatches == 0 && force_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pgf_pkg.sv
sv/pgf_mul.sv
sv/pgf_div.sv
sv/pairwise_gravity_force_top.sv
dv/pairwise_gravity_force_top_test.sv
